/* hw/rtl/tmaa_pkg.sv */
// Shared constants for the temperature moving-average alarm block.
// Fixed-point scale factors and constant-divide reciprocals used by the datapath.
// No dependencies.
package tmaa_pkg;

    // Raw sample width and the stored, offset Celsius width (raw * 90 fits in 19 bits).
    localparam int unsigned RAW_W  = 12;
    localparam int unsigned OFF_W  = 19;
    localparam int unsigned THR_W  = 12;
    localparam int unsigned CEL_W  = 20;
    localparam int unsigned FAH_W  = 21;

    // Celsius Q8 is raw * 90 - 279 * 256; entries are kept as raw * 90 so they stay unsigned.
    localparam logic [6:0]        RAW_GAIN = 7'd90;
    localparam logic [OFF_W-1:0]  CEL_OFF  = 19'd71424;

    // Fahrenheit: floor((9q + 4) / 5) computed as (q * 9M + 4M) >> 25 with M = ceil(2^25 / 5).
    localparam int unsigned       FMUL_W   = 26;
    localparam int unsigned       FPROD_W  = OFF_W + FMUL_W;
    localparam int unsigned       F_SHIFT  = 25;
    localparam logic [FMUL_W-1:0] F_MUL    = 26'd60397983;
    localparam logic [FMUL_W-1:0] F_ADD    = 26'd26843548;
    // 128564 removes the divide offset, 8192 adds the 32 degree shift.
    localparam logic [FAH_W-1:0]  F_OFF    = 21'd120372;

    localparam logic [THR_W-1:0]  THR_RESET = 12'd40;

endpackage

/* hw/rtl/tmaa_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Used for the sample window store; no dependencies.
module tmaa_ram #(
    parameter int unsigned WIDTH = 19,
    parameter int unsigned DEPTH = 50
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/temperature_moving_average_alarm.sv */
// Temperature moving-average filter with over-temperature alarm, top level.
// Depends on tmaa_pkg for constants and on tmaa_ram for the window store.
//
// Usage:
// A request on the slave stream carries one raw 12-bit sensor sample in tdata and the
// display unit select in tuser (0 Celsius, 1 Fahrenheit). Every request yields exactly
// one result on the master stream: the window mean in Celsius Q8, the same mean in
// Fahrenheit Q8, the value picked by the unit select, and the alarm flag.
// The alarm threshold (signed whole degrees Celsius) is written on the cfg channel,
// which is always ready; write it only while no request is in flight.
//
// Timing: the datapath is a five-stage pipeline (window read, running-sum update,
// mean multiply, Fahrenheit multiply, output register). One request is taken every
// cycle while the master side does not stall. The rate is set by the window RAM,
// which gets one read and one write per request.
// When the master side stalls, the whole pipeline holds and s_axis_tready drops in the
// same cycle; the output register keeps its result until it is taken.
// Reset clears the pipeline, sets the running sum to a window of zero degrees and marks
// every window entry as unwritten, so the window starts at zero with no clearing pass.
module temperature_moving_average_alarm #(
    parameter int unsigned WINDOW_LENGTH = 50
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Sample stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] adc_sample, [15:12] zero
    input  logic        s_axis_tuser,   // [0] mode
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [19:0] mean_celsius, [40:20] mean_fahrenheit, [61:41] shown_value,
    // [62] over_limit, [63] zero
    output logic [63:0] m_axis_tdata,
    // Threshold register write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [11:0] i_cfg_data
);

    localparam int unsigned IDX_W   = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int unsigned OFF_W   = tmaa_pkg::OFF_W;
    localparam int unsigned SUM_W   = OFF_W + IDX_W;
    localparam int unsigned SHIFT   = SUM_W + IDX_W;
    localparam int unsigned PROD_W  = 2 * SUM_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LENGTH - 1);
    localparam logic [SUM_W-1:0] SUM_RESET =
        SUM_W'(64'(WINDOW_LENGTH) * 64'(tmaa_pkg::CEL_OFF));
    localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(64'(WINDOW_LENGTH) * 64'd368550);
    // Reciprocal of the window length; exact floor for every sum below 2^SUM_W.
    localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'(
        ((64'd1 << SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));

    // Pipeline control.
    logic adv;
    logic accept;

    // Accept stage state.
    logic [IDX_W-1:0]         r_idx;
    logic [IDX_W-1:0]         n_idx;
    logic [WINDOW_LENGTH-1:0] r_written;

    // Stage 1: window entry read back.
    logic                     r_s1_valid;
    logic                     r_s1_mode;
    logic [OFF_W-1:0]         r_s1_off;
    logic [IDX_W-1:0]         r_s1_idx;
    logic [OFF_W-1:0]         ram_rdata;
    logic [OFF_W-1:0]         old_off;
    logic                     ram_we;

    // Running sum of raw*90 over the window; a zero-degree entry counts as CEL_OFF.
    logic [SUM_W-1:0]         r_osum;
    logic [SUM_W-1:0]         n_osum;

    // Stage 2: sum ready for the divide.
    logic                     r_s2_valid;
    logic                     r_s2_mode;

    // Stage 3: mean product.
    logic                     r_s3_valid;
    logic                     r_s3_mode;
    logic [PROD_W-1:0]        r_s3_prod;
    logic [OFF_W-1:0]         s3_q;

    // Stage 4: offset mean and Fahrenheit product.
    logic                         r_s4_valid;
    logic                         r_s4_mode;
    logic [OFF_W-1:0]             r_s4_q;
    logic [tmaa_pkg::FPROD_W-1:0] r_s4_fprod;
    logic [tmaa_pkg::CEL_W-1:0]   s4_cel;
    logic [tmaa_pkg::FAH_W-1:0]   s4_fah;
    logic [tmaa_pkg::FAH_W-1:0]   s4_limit;
    logic                         s4_over;

    // Output register.
    logic                       r_out_valid;
    logic [tmaa_pkg::CEL_W-1:0] r_out_cel;
    logic [tmaa_pkg::FAH_W-1:0] r_out_fah;
    logic [tmaa_pkg::FAH_W-1:0] r_out_shown;
    logic                       r_out_over;

    logic [tmaa_pkg::THR_W-1:0] r_thr;

    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;
    assign o_cfg_ready   = 1'b1;

    assign n_idx = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;

    tmaa_ram #(
        .WIDTH (OFF_W),
        .DEPTH (WINDOW_LENGTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_idx),
        .i_wdata (r_s1_off),
        .i_re    (accept),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // An entry never written since reset still holds zero degrees.
    assign old_off = r_written[r_s1_idx] ? ram_rdata : tmaa_pkg::CEL_OFF;
    assign ram_we  = adv && r_s1_valid;
    assign n_osum  = r_osum + SUM_W'(r_s1_off) - SUM_W'(old_off);

    assign s3_q = r_s3_prod[SHIFT +: OFF_W];

    assign s4_cel   = tmaa_pkg::CEL_W'(r_s4_q) - tmaa_pkg::CEL_W'(tmaa_pkg::CEL_OFF);
    assign s4_fah   = tmaa_pkg::FAH_W'(r_s4_fprod >> tmaa_pkg::F_SHIFT) - tmaa_pkg::F_OFF;
    assign s4_limit = (tmaa_pkg::FAH_W'($signed(r_thr)) << 8)
                      + tmaa_pkg::FAH_W'(tmaa_pkg::CEL_OFF);
    assign s4_over  = $signed(tmaa_pkg::FAH_W'(r_s4_q)) > $signed(s4_limit);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_written   <= '0;
            r_osum      <= SUM_RESET;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_thr       <= tmaa_pkg::THR_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (accept) begin
                r_idx <= n_idx;
            end
            if (ram_we) begin
                r_written[r_s1_idx] <= 1'b1;
                r_osum              <= n_osum;
            end
            if (adv) begin
                r_s1_valid  <= accept;
                r_s2_valid  <= r_s1_valid;
                r_s3_valid  <= r_s2_valid;
                r_s4_valid  <= r_s3_valid;
                r_out_valid <= r_s4_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mode <= s_axis_tuser;
            r_s1_off  <= OFF_W'(s_axis_tdata[tmaa_pkg::RAW_W-1:0]) * OFF_W'(tmaa_pkg::RAW_GAIN);
            r_s1_idx  <= r_idx;
        end
        if (adv) begin
            r_s2_mode  <= r_s1_mode;
            r_s3_mode  <= r_s2_mode;
            r_s3_prod  <= PROD_W'(r_osum) * PROD_W'(RECIP);
            r_s4_mode  <= r_s3_mode;
            r_s4_q     <= s3_q;
            r_s4_fprod <= tmaa_pkg::FPROD_W'(s3_q) * tmaa_pkg::FPROD_W'(tmaa_pkg::F_MUL)
                          + tmaa_pkg::FPROD_W'(tmaa_pkg::F_ADD);
            r_out_cel   <= s4_cel;
            r_out_fah   <= s4_fah;
            r_out_shown <= r_s4_mode ? s4_fah : tmaa_pkg::FAH_W'($signed(s4_cel));
            r_out_over  <= s4_over;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_over, r_out_shown, r_out_fah, r_out_cel};

    // The next-slot pointer always addresses a slot inside the window.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_IDX)
        else $error("window pointer out of range");

    // A read and a write of the same entry never meet in one cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && accept && (r_s1_idx == r_idx)))
        else $error("window read and write collide");

    // The offset running sum stays within a full window of hottest samples.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_osum <= SUM_MAX)
        else $error("running sum out of range");

    // A stalled receiver freezes the whole pipeline, including the running sum.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> $stable(r_osum) && $stable(r_idx))
        else $error("pipeline moved while stalled");

endmodule

/* tb/testbench.sv */
// Testbench for the temperature moving-average alarm block.
// It predicts every result, including the window mean, Fahrenheit and alarm, and checks each one
// field by field. Depends on the RTL top level temperature_moving_average_alarm only.
`timescale 1ns / 100ps

module testbench;

    localparam int WINDOW_LENGTH  = 50;
    localparam int PIPE_LATENCY   = 5;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_READINGS = 200;
    localparam int CEL_OFFSET_Q8  = 71424;
    localparam int FAH_OFFSET_Q8  = 8192;

    typedef struct packed {
        logic [19:0] mean_c;
        logic [20:0] mean_f;
        logic [20:0] shown;
        logic        alarm;
    } t_temp_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // [11:0] adc_sample, [15:12] zero
    logic        s_axis_tuser = 1'b0;  // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [19:0] mean_celsius, [40:20] mean_fahrenheit, [61:41] shown_value, [62] over_limit
    logic [63:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [11:0] i_cfg_data = '0;

    // Predictor state: the window in Celsius Q8, its sum, the slot to replace next, the limit.
    int          window_q8 [WINDOW_LENGTH];
    longint      window_sum;
    int          oldest_slot;
    int          alarm_limit;

    t_temp_result pending_readings [$];
    t_temp_result result_want;
    t_temp_result result_got;

    int          mismatch_count = 0;
    int          readings_sent = 0;
    int          readings_checked = 0;
    int          threshold_writes = 0;
    int          alarms_seen = 0;
    int          cycle_count = 0;
    int          sender_idle_odds = 0;
    int          receiver_stall_odds = 0;
    int          stall_left = 0;

    temperature_moving_average_alarm #(
        .WINDOW_LENGTH(WINDOW_LENGTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending_readings.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic longint floor_div(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    // Runs one sample through the predicted window and returns the result it should produce.
    function automatic t_temp_result predict_reading(input logic [11:0] raw, input logic mode);
        int           celsius_q8;
        longint       mean;
        longint       fmean;
        t_temp_result r;
        celsius_q8 = int'(raw) * 90 - CEL_OFFSET_Q8;
        window_sum = window_sum + celsius_q8 - window_q8[oldest_slot];
        window_q8[oldest_slot] = celsius_q8;
        oldest_slot = (oldest_slot == WINDOW_LENGTH - 1) ? 0 : oldest_slot + 1;
        mean  = floor_div(window_sum, WINDOW_LENGTH);
        fmean = floor_div(mean * 9, 5) + FAH_OFFSET_Q8;
        r.mean_c = mean[19:0];
        r.mean_f = fmean[20:0];
        r.shown  = mode ? fmean[20:0] : mean[20:0];
        r.alarm  = (mean > longint'(alarm_limit) * 256);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("Mismatch on %s at cycle %0d: expected %0d, got %0d",
                     what, cycle_count, want, got);
        end
    endtask

    // Each accepted result is checked against the oldest outstanding prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            result_got.mean_c = m_axis_tdata[19:0];
            result_got.mean_f = m_axis_tdata[40:20];
            result_got.shown  = m_axis_tdata[61:41];
            result_got.alarm  = m_axis_tdata[62];
            if (pending_readings.size() == 0) begin
                report_mismatch("unexpected result, mean_celsius", 0,
                                int'($signed(result_got.mean_c)));
            end else begin
                result_want = pending_readings.pop_front();
                readings_checked++;
                if (result_want.alarm) begin
                    alarms_seen++;
                end
                if (result_got.mean_c !== result_want.mean_c) begin
                    report_mismatch("mean_celsius", int'($signed(result_want.mean_c)),
                                    int'($signed(result_got.mean_c)));
                end
                if (result_got.mean_f !== result_want.mean_f) begin
                    report_mismatch("mean_fahrenheit", int'($signed(result_want.mean_f)),
                                    int'($signed(result_got.mean_f)));
                end
                if (result_got.shown !== result_want.shown) begin
                    report_mismatch("shown_value", int'($signed(result_want.shown)),
                                    int'($signed(result_got.shown)));
                end
                if (result_got.alarm !== result_want.alarm) begin
                    report_mismatch("over_limit", int'(result_want.alarm),
                                    int'(result_got.alarm));
                end
            end
        end
    end

    // The result side stalls in bursts; a stall odds of zero keeps it always ready.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (receiver_stall_odds != 0 && $urandom_range(1, receiver_stall_odds) == 1) begin
            stall_left <= $urandom_range(0, 13);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Starts and ends at a falling edge; the valid stays high so the next request can follow.
    task automatic send_sample(input logic [11:0] raw, input logic mode);
        if (sender_idle_odds != 0 && $urandom_range(1, sender_idle_odds) == 1) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {4'b0000, raw};
        s_axis_tuser  = mode;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_readings.push_back(predict_reading(raw, mode));
        readings_sent++;
        @(negedge i_clk);
    endtask

    // The threshold changes only once the pipeline has drained.
    task automatic write_threshold(input logic signed [11:0] value);
        s_axis_tvalid = 1'b0;
        while (pending_readings.size() != 0) @(negedge i_clk);
        repeat (PIPE_LATENCY + 1) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        alarm_limit = int'(value);
        threshold_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Warm-up with the reset threshold: the zeros left by reset still weigh in every mean.
    task automatic test_warmup_extremes();
        sender_idle_odds    = 5;
        receiver_stall_odds = 5;
        send_sample(12'd0, 1'b0);
        send_sample(12'd4095, 1'b1);
        send_sample(12'h800, 1'b0);
        send_sample(12'h7FF, 1'b1);
        send_sample(12'hAAA, 1'b0);
        send_sample(12'h555, 1'b1);
        send_sample(12'd794, 1'b0);
        send_sample(12'd793, 1'b1);
        send_sample(12'd4095, 1'b0);
        send_sample(12'd4095, 1'b1);
        send_sample(12'd4095, 1'b0);
        send_sample(12'd0, 1'b1);
    endtask

    // Lowest and highest thresholds in range, then the extremes of the 12-bit field.
    task automatic test_threshold_extremes();
        write_threshold(-12'sd279);
        send_sample(12'd0, 1'b0);
        send_sample(12'd2000, 1'b1);
        send_sample(12'd0, 1'b1);
        write_threshold(12'sd1161);
        send_sample(12'd4095, 1'b0);
        send_sample(12'd4095, 1'b1);
        send_sample(12'd0, 1'b0);
        write_threshold(12'sh800);
        send_sample(12'd1, 1'b1);
        send_sample(12'd4094, 1'b0);
        write_threshold(12'sh7FF);
        send_sample(12'd3000, 1'b1);
        send_sample(12'd100, 1'b0);
    endtask

    // Random traffic in phases, each with its own threshold and idling pattern. Most runs hold
    // the sensor near one level for 30 to 80 samples, often long enough to fill the window, so
    // the mean settles and sweeps across the threshold; the rest is full-scale runs and noise.
    task automatic test_random_traffic();
        int          phase;
        int          phase_end;
        int          run_kind;
        int          run_len;
        int          base;
        int          spread;
        int          sample;
        logic        run_mode;
        logic [11:0] thr;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if ($urandom_range(0, 3) == 0) begin
                thr = 12'($urandom_range(0, 4095));
            end else begin
                thr = 12'($signed($urandom_range(0, 1440)) - 279);
            end
            write_threshold($signed(thr));
            if (phase == RANDOM_PHASES - 1) begin
                sender_idle_odds    = 0;
                receiver_stall_odds = 0;
            end else begin
                sender_idle_odds    = $urandom_range(0, 3) * 4;
                receiver_stall_odds = $urandom_range(0, 3) * 4;
            end
            phase_end = readings_sent + PHASE_READINGS;
            while (readings_sent < phase_end) begin
                run_kind = $urandom_range(0, 9);
                run_mode = 1'($urandom_range(0, 1));
                base     = $urandom_range(0, 4095);
                spread   = $urandom_range(0, 40);
                run_len  = (run_kind < 8) ? $urandom_range(30, 80) : $urandom_range(10, 40);
                if (run_kind >= 6 && run_kind < 8) begin
                    base   = $urandom_range(0, 1) ? 4095 : 0;
                    spread = 0;
                    run_len = $urandom_range(50, 60);
                end
                // The last run of a phase is cut short so every phase sends the same count.
                if (run_len > phase_end - readings_sent) begin
                    run_len = phase_end - readings_sent;
                end
                repeat (run_len) begin
                    if (run_kind >= 8) begin
                        sample = $urandom_range(0, 4095);
                    end else begin
                        sample = base + $urandom_range(0, 2 * spread) - spread;
                        sample = (sample < 0) ? 0 : (sample > 4095) ? 4095 : sample;
                    end
                    if ($urandom_range(0, 7) == 0) begin
                        run_mode = ~run_mode;
                    end
                    send_sample(12'(sample), run_mode);
                end
            end
        end
    endtask

    initial begin
        for (int i = 0; i < WINDOW_LENGTH; i++) begin
            window_q8[i] = 0;
        end
        window_sum  = 0;
        oldest_slot = 0;
        alarm_limit = 40;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_warmup_extremes();
        test_threshold_extremes();
        test_random_traffic();

        s_axis_tvalid = 1'b0;
        while (pending_readings.size() != 0) @(negedge i_clk);
        repeat (PIPE_LATENCY * 4) @(negedge i_clk);

        $display("Checked %0d of %0d readings, %0d with the alarm raised, %0d mismatches.",
                 readings_checked, readings_sent, alarms_seen, mismatch_count);
        $display("Threshold was rewritten %0d times; the window wrapped %0d times.",
                 threshold_writes, readings_sent / WINDOW_LENGTH);
        if (mismatch_count == 0 && readings_checked == readings_sent) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* temperature_moving_average_alarm.f */
hw/rtl/tmaa_pkg.sv
hw/rtl/tmaa_ram.sv
hw/rtl/temperature_moving_average_alarm.sv
tb/testbench.sv
